// ===== hdl/bmhp_pkg.sv =====
// Shared types, codes and constants of the BUFR message header parser.
package bmhp_pkg;

    // Default width of byte counts and section lengths
    localparam int LENGTH_BITS_DEF = 24;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_DESC_LIMIT = 1'b0;   // register index taken from paddr[2]
    localparam logic [15:0] DESC_LIMIT_RST = 16'd256;

    // Field codes on the result stream
    localparam logic [4:0] FID_TOTAL_LEN  = 5'd0;
    localparam logic [4:0] FID_EDITION    = 5'd1;
    localparam logic [4:0] FID_SEC1_LEN   = 5'd2;
    localparam logic [4:0] FID_MASTER_TBL = 5'd3;
    localparam logic [4:0] FID_CENTRE     = 5'd4;
    localparam logic [4:0] FID_SUBCENTRE  = 5'd5;
    localparam logic [4:0] FID_UPDATE_SEQ = 5'd6;
    localparam logic [4:0] FID_OPTIONS    = 5'd7;
    localparam logic [4:0] FID_YEAR       = 5'd13;
    localparam logic [4:0] FID_SEC2_LEN   = 5'd19;
    localparam logic [4:0] FID_SEC3_LEN   = 5'd20;
    localparam logic [4:0] FID_SUBSETS    = 5'd21;
    localparam logic [4:0] FID_FLAGS      = 5'd22;
    localparam logic [4:0] FID_DESCRIPTOR = 5'd23;
    localparam logic [4:0] FID_SEC4_LEN   = 5'd24;
    localparam logic [4:0] FID_FINAL      = 5'd25;

    // Closing status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
    localparam logic [2:0] ST_BAD_START   = 3'd2;
    localparam logic [2:0] ST_BAD_END     = 3'd3;
    localparam logic [2:0] ST_LEN_MISMATCH = 3'd4;

    // Message constants
    localparam logic [31:0] END_MARK      = 32'h3737_3737;   // "7777"
    localparam logic [7:0]  OPT_SEC2_BIT  = 8'h80;
    localparam int          MIN_MSG_BYTES = 8;

    // Section walk
    typedef enum logic [2:0] {
        SEC0 = 3'd0,
        SEC1 = 3'd1,
        SEC2 = 3'd2,
        SEC3 = 3'd3,
        SEC4 = 3'd4,
        SEC_DONE = 3'd5
    } sec_t;

    // One result transfer
    typedef struct packed {
        logic        valid;
        logic [4:0]  fid;
        logic [23:0] value;
        logic [1:0]  df;
        logic [5:0]  dx;
        logic [7:0]  dy;
        logic [2:0]  status;
        logic        fin;
    } res_t;

    // Expected start marker "BUFR"
    function automatic logic [7:0] start_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h42;
            2'd1:    c = 8'h55;
            2'd2:    c = 8'h46;
            default: c = 8'h52;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/bmhp_cfg.sv =====
// APB register block holding the descriptor limit.
module bmhp_cfg
    import bmhp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [15:0]           desc_limit
);

    logic [15:0] desc_limit_reg;
    logic [15:0] desc_limit_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // Register write, word aligned
    always_comb
    begin
        desc_limit_next = desc_limit_reg;
        if (wr_en && paddr[2] == REG_DESC_LIMIT)
        begin
            desc_limit_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_limit_reg <= DESC_LIMIT_RST;
        end
        else
        begin
            desc_limit_reg <= desc_limit_next;
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_DESC_LIMIT)
        begin
            prdata = {{(APB_DATA_W-16){1'b0}}, desc_limit_reg};
        end
    end

    assign desc_limit = desc_limit_reg;

endmodule

// ===== hdl/bmhp_parse.sv =====
// Byte parser: section walk, field extraction and closing checks.
module bmhp_parse
    import bmhp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [15:0] desc_limit,
    output res_t        res
);

    localparam int LB = LENGTH_BITS;

    logic [LB-1:0] byte_count_reg, byte_count_next;
    sec_t          sec_reg, sec_next;
    logic [LB-1:0] sec_off_reg, sec_off_next;
    logic [LB-1:0] sec_len_reg, sec_len_next;
    logic [LB-1:0] decl_len_reg, decl_len_next;
    logic [23:0]   acc_reg, acc_next;
    logic          start_ok_reg, start_ok_next;
    logic [31:0]   tail_reg, tail_next;
    logic          opt_reg, opt_next;
    logic [15:0]   desc_cnt_reg, desc_cnt_next;
    logic [7:0]    desc_hi_reg, desc_hi_next;

    logic [LB-1:0] pos;
    logic [LB-1:0] off;
    logic [LB-1:0] off_inc;
    logic [LB-1:0] acc_len;
    logic [LB-1:0] cnt_upd;
    logic          start_ok_upd;
    logic          walked;
    sec_t          sec_walk;
    logic [LB-1:0] off_walk;
    res_t          fld;

    assign pos     = byte_count_reg;
    assign off     = sec_off_reg;
    assign off_inc = (off != {LB{1'b1}}) ? off + LB'(1) : off;
    assign acc_next = {acc_reg[15:0], data_byte};
    assign tail_next = {tail_reg[23:0], data_byte};
    assign acc_len  = acc_next[LB-1:0];
    assign cnt_upd  = (pos != {LB{1'b1}}) ? pos + LB'(1) : pos;
    assign start_ok_upd = start_ok_reg &
        !((pos < LB'(4)) && (data_byte != start_char(pos[1:0])));

    // Field extraction and data state updates
    always_comb
    begin
        fld           = '0;
        sec_len_next  = sec_len_reg;
        decl_len_next = decl_len_reg;
        opt_next      = opt_reg;
        desc_cnt_next = desc_cnt_reg;
        desc_hi_next  = desc_hi_reg;
        unique case (sec_reg)
            SEC0:
            begin
                if (off == LB'(6))
                begin
                    decl_len_next = acc_len;
                    fld.valid = 1'b1; fld.fid = FID_TOTAL_LEN; fld.value = 24'(acc_len);
                end
                else if (off == LB'(7))
                begin
                    fld.valid = 1'b1; fld.fid = FID_EDITION; fld.value = 24'(data_byte);
                end
            end
            SEC1:
            begin
                if (off == LB'(2))
                begin
                    sec_len_next = acc_len;
                    fld.valid = 1'b1; fld.fid = FID_SEC1_LEN; fld.value = 24'(acc_len);
                end
                else if (off == LB'(3))
                begin
                    fld.valid = 1'b1; fld.fid = FID_MASTER_TBL; fld.value = 24'(data_byte);
                end
                else if (off == LB'(5))
                begin
                    fld.valid = 1'b1; fld.fid = FID_CENTRE; fld.value = 24'(acc_next[15:0]);
                end
                else if (off == LB'(7))
                begin
                    fld.valid = 1'b1; fld.fid = FID_SUBCENTRE;
                    fld.value = 24'(acc_next[15:0]);
                end
                else if (off == LB'(8))
                begin
                    fld.valid = 1'b1; fld.fid = FID_UPDATE_SEQ; fld.value = 24'(data_byte);
                end
                else if (off == LB'(9))
                begin
                    fld.valid = 1'b1; fld.fid = FID_OPTIONS; fld.value = 24'(data_byte);
                    opt_next = |(data_byte & OPT_SEC2_BIT);
                end
                else if (off >= LB'(10) && off <= LB'(14))
                begin
                    // category through local table version
                    fld.valid = 1'b1; fld.fid = off[4:0] - 5'd2; fld.value = 24'(data_byte);
                end
                else if (off == LB'(16))
                begin
                    fld.valid = 1'b1; fld.fid = FID_YEAR; fld.value = 24'(acc_next[15:0]);
                end
                else if (off >= LB'(17) && off <= LB'(21))
                begin
                    // month through second
                    fld.valid = 1'b1; fld.fid = off[4:0] - 5'd3; fld.value = 24'(data_byte);
                end
            end
            SEC2:
            begin
                if (off == LB'(2))
                begin
                    sec_len_next = acc_len;
                    fld.valid = 1'b1; fld.fid = FID_SEC2_LEN; fld.value = 24'(acc_len);
                end
            end
            SEC3:
            begin
                if (off == LB'(2))
                begin
                    sec_len_next = acc_len;
                    fld.valid = 1'b1; fld.fid = FID_SEC3_LEN; fld.value = 24'(acc_len);
                end
                else if (off == LB'(5))
                begin
                    fld.valid = 1'b1; fld.fid = FID_SUBSETS; fld.value = 24'(acc_next[15:0]);
                end
                else if (off == LB'(6))
                begin
                    fld.valid = 1'b1; fld.fid = FID_FLAGS;
                    fld.value = {22'd0, data_byte[7], data_byte[6]};
                end
                else if (off >= LB'(7))
                begin
                    // descriptors: high byte at odd offsets, low byte completes it
                    if (off[0])
                    begin
                        desc_hi_next = data_byte;
                    end
                    else if (desc_cnt_reg < desc_limit)
                    begin
                        fld.valid = 1'b1; fld.fid = FID_DESCRIPTOR;
                        fld.value = 24'(acc_next[15:0]);
                        fld.df = desc_hi_reg[7:6];
                        fld.dx = desc_hi_reg[5:0];
                        fld.dy = data_byte;
                        desc_cnt_next = desc_cnt_reg + 16'd1;
                    end
                end
            end
            SEC4:
            begin
                if (off == LB'(2))
                begin
                    sec_len_next = acc_len;
                    fld.valid = 1'b1; fld.fid = FID_SEC4_LEN; fld.value = 24'(acc_len);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Section walk: next section and offset
    always_comb
    begin
        walked   = 1'b0;
        sec_walk = sec_reg;
        off_walk = off_inc;
        unique case (sec_reg)
            SEC0:
            begin
                if (off == LB'(7))
                begin
                    walked = 1'b1; sec_walk = SEC1; off_walk = '0;
                end
            end
            SEC4:
            begin
                if (off == LB'(2))
                begin
                    walked = 1'b1; sec_walk = SEC_DONE; off_walk = '0;
                end
            end
            SEC1, SEC2, SEC3:
            begin
            end
            default:
            begin
                walked = 1'b1; off_walk = off;
            end
        endcase
        if (!walked && sec_reg != SEC0)
        begin
            // a section closes at offset max(2, length-1)
            if (off >= LB'(2) && ({1'b0, off} + (LB+1)'(1)) >= {1'b0, sec_len_next})
            begin
                off_walk = '0;
                unique case (sec_reg)
                    SEC1:    sec_walk = opt_next ? SEC2 : SEC3;
                    SEC2:    sec_walk = SEC3;
                    default: sec_walk = SEC4;
                endcase
            end
        end
    end

    // Result selection, closing checks and state commit
    always_comb
    begin
        res = fld;
        if (!start_ok_upd)
        begin
            res = '0;
        end
        byte_count_next = cnt_upd;
        start_ok_next   = start_ok_upd;
        sec_next        = sec_walk;
        if (last_byte)
        begin
            res        = '0;
            res.valid  = 1'b1;
            res.fid    = FID_FINAL;
            res.value  = 24'(cnt_upd);
            res.fin    = 1'b1;
            if (cnt_upd < LB'(MIN_MSG_BYTES))
            begin
                res.status = ST_TOO_SHORT;
            end
            else if (!start_ok_upd)
            begin
                res.status = ST_BAD_START;
            end
            else if (tail_next != END_MARK)
            begin
                res.status = ST_BAD_END;
            end
            else if (decl_len_next != cnt_upd)
            begin
                res.status = ST_LEN_MISMATCH;
            end
            else
            begin
                res.status = ST_OK;
            end
        end
    end

    // Message state; the final byte returns it to the reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            sec_reg        <= SEC0;
            sec_off_reg    <= '0;
            sec_len_reg    <= '0;
            decl_len_reg   <= '0;
            acc_reg        <= '0;
            start_ok_reg   <= 1'b1;
            tail_reg       <= '0;
            opt_reg        <= 1'b0;
            desc_cnt_reg   <= '0;
            desc_hi_reg    <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                byte_count_reg <= '0;
                sec_reg        <= SEC0;
                sec_off_reg    <= '0;
                sec_len_reg    <= '0;
                decl_len_reg   <= '0;
                acc_reg        <= '0;
                start_ok_reg   <= 1'b1;
                tail_reg       <= '0;
                opt_reg        <= 1'b0;
                desc_cnt_reg   <= '0;
                desc_hi_reg    <= '0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                sec_reg        <= sec_next;
                sec_off_reg    <= off_walk;
                sec_len_reg    <= sec_len_next;
                decl_len_reg   <= decl_len_next;
                acc_reg        <= acc_next;
                start_ok_reg   <= start_ok_next;
                tail_reg       <= tail_next;
                opt_reg        <= opt_next;
                desc_cnt_reg   <= desc_cnt_next;
                desc_hi_reg    <= desc_hi_next;
            end
        end
    end

endmodule

// ===== hdl/bufr_message_header_parser.sv =====
// Top level of the BUFR message header parser: input stage, parser, result stage.
//
//  Channel   Role            Transfer contents
//  s_*       byte input      tdata = data_byte, tlast = last_byte
//  m_*       field output    tuser = field_id, tdata = value/F/X/Y/status, tlast = final_res
//  APB       configuration   descriptor_limit at byte address 0
//
// A byte is parsed while it sits in the input register and its result is
// registered in the result register when the parser advances; one byte per
// cycle sustained while m_tready does not stall the result register.
// The parser state advances only when the result register can take a result.
// A stall on m_tready holds the result register and fills the input register,
// after which s_tready drops. rst_n clears all control state asynchronously.
module bufr_message_header_parser
    import bmhp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // byte input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] data_byte
    input  logic                  s_tlast,
    // field output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,    // [23:0] field_value, [25:24] desc_f,
                                              // [31:26] desc_x, [39:32] desc_y,
                                              // [42:40] status, [47:43] zero
    output logic [4:0]            m_tuser,    // [4:0] field_id
    output logic                  m_tlast,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg, out_valid_next;
    res_t        out_reg;
    res_t        res;
    logic        advance;
    logic [15:0] desc_limit;

    bmhp_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .desc_limit (desc_limit)
    );

    bmhp_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .data_byte  (in_byte_reg),
        .last_byte  (in_last_reg),
        .desc_limit (desc_limit),
        .res        (res)
    );

    // Flow control between the two register stages
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        if (advance)
        begin
            out_valid_next = res.valid;
        end
        else
        begin
            out_valid_next = out_valid_reg & ~m_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && res.valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.fid;
    assign m_tlast  = out_reg.fin;
    assign m_tdata  = {5'd0, out_reg.status, out_reg.dy, out_reg.dx, out_reg.df,
                       out_reg.value};

endmodule
